FILE: rtl/core/cascaded_onepole_bandpass_assert.svh
// assertion macros for the cascaded one-pole band filter
`ifndef CASCADED_ONEPOLE_BANDPASS_ASSERT_SVH
`define CASCADED_ONEPOLE_BANDPASS_ASSERT_SVH

// same-cycle implication
`define CVBP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CVBP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/cvbp_pkg.sv
// types, constants and helper functions of the cascaded one-pole band filter
package cvbp_pkg;

	typedef logic signed [23:0] volt_t;
	typedef logic        [16:0] coef_t;
	typedef logic signed [17:0] offs_t;
	typedef logic        [19:0] quot_t;
	typedef logic signed [20:0] dten_t;
	typedef logic signed [21:0] csum_t;
	typedef logic signed [24:0] opnd_t;
	typedef logic signed [49:0] prod_t;

	localparam coef_t COEF_ONE    = 17'd65536;
	localparam volt_t TEN_VOLTS   = 24'sd655360;
	localparam opnd_t RECIP10     = 25'sd13421773;
	localparam int    RECIP_SHIFT = 27;
	localparam prod_t ROUND_HALF  = 50'sd32768;

	localparam logic [1:0] CFG_POLE_COUNT = 2'd0;
	localparam logic [1:0] CFG_POT_F      = 2'd1;
	localparam logic [1:0] CFG_POT_R      = 2'd2;

	function automatic coef_t pot_val(input coef_t p);
		return (p > COEF_ONE) ? COEF_ONE : p;
	endfunction

	function automatic coef_t clamp_coef(input csum_t v);
		coef_t r;
		if (v < 0)
			r = '0;
		else if (v > $signed({5'b0, COEF_ONE}))
			r = COEF_ONE;
		else
			r = v[16:0];
		return r;
	endfunction

	function automatic coef_t cv_coef(input volt_t v, input quot_t q);
		coef_t r;
		if (v < 0)
			r = '0;
		else if (v > TEN_VOLTS)
			r = COEF_ONE;
		else
			r = q[16:0];
		return r;
	endfunction

	function automatic dten_t signed_tenth(input logic neg, input quot_t q);
		dten_t m;
		m = $signed({1'b0, q});
		return neg ? -m : m;
	endfunction

	function automatic volt_t sat_volt(input logic signed [24:0] v);
		volt_t r;
		if (v > 25'sd8388607)
			r = 24'sd8388607;
		else if (v < -25'sd8388608)
			r = -24'sd8388608;
		else
			r = v[23:0];
		return r;
	endfunction

endpackage

FILE: rtl/core/cvbp_mul.sv
// shared registered signed multiplier
module cvbp_mul (
	input  logic            clk,
	input  cvbp_pkg::opnd_t a,
	input  cvbp_pkg::opnd_t b,
	output cvbp_pkg::prod_t p
);

	cvbp_pkg::prod_t p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

FILE: rtl/core/cvbp_coef.sv
// coefficient selection from control voltages, pots and link mode
module cvbp_coef (
	input  logic            link_on,
	input  cvbp_pkg::offs_t link_offset,
	input  logic            rp,
	input  logic            fp,
	input  cvbp_pkg::volt_t rv,
	input  cvbp_pkg::volt_t fv,
	input  cvbp_pkg::quot_t qr,
	input  cvbp_pkg::quot_t qf,
	input  cvbp_pkg::coef_t pot_f,
	input  cvbp_pkg::coef_t pot_r,
	output cvbp_pkg::coef_t fc,
	output cvbp_pkg::coef_t rc,
	output logic            ffrom,
	output logic            rfrom
);

	cvbp_pkg::dten_t dr;
	cvbp_pkg::dten_t df;
	cvbp_pkg::csum_t dr_x;
	cvbp_pkg::csum_t df_x;
	cvbp_pkg::csum_t off_x;
	cvbp_pkg::csum_t potr_x;

	always_comb begin
		dr     = cvbp_pkg::signed_tenth(rv[23], qr);
		df     = cvbp_pkg::signed_tenth(fv[23], qf);
		dr_x   = $signed({dr[20], dr});
		df_x   = $signed({df[20], df});
		off_x  = $signed({{4{link_offset[17]}}, link_offset});
		potr_x = $signed({5'b0, cvbp_pkg::pot_val(pot_r)});

		rfrom = rp;
		rc    = rp ? cvbp_pkg::cv_coef(rv, qr) : cvbp_pkg::pot_val(pot_r);
		ffrom = fp;
		fc    = fp ? cvbp_pkg::cv_coef(fv, qf) : cvbp_pkg::pot_val(pot_f);

		if (link_on) begin
			ffrom = 1'b1;
			if (rp) begin
				fc = cvbp_pkg::clamp_coef(dr_x + off_x);
			end else if (fp) begin
				rfrom = 1'b1;
				rc    = cvbp_pkg::clamp_coef(df_x - off_x);
				fc    = cvbp_pkg::clamp_coef(df_x);
			end else begin
				fc = cvbp_pkg::clamp_coef(potr_x + off_x);
			end
		end
	end

endmodule

FILE: rtl/core/cvbp_bank.sv
// stage storage of one channel with the one-pole update
module cvbp_bank #(
	parameter int MAX_STAGES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [$clog2(2*MAX_STAGES)-1:0]     rd_idx,
	output cvbp_pkg::volt_t                     rd_data,
	input  logic                                wr_en,
	input  logic [$clog2(2*MAX_STAGES)-1:0]     wr_idx,
	input  cvbp_pkg::volt_t                     s_old,
	input  cvbp_pkg::prod_t                     prod,
	output cvbp_pkg::volt_t                     s_new
);

	localparam int DEPTH = 2 * MAX_STAGES;

	cvbp_pkg::volt_t     st_q [DEPTH];
	cvbp_pkg::prod_t     rnd;
	logic signed [24:0]  delta;
	logic signed [25:0]  sum;

	always_comb begin
		rnd   = prod + cvbp_pkg::ROUND_HALF;
		delta = rnd[40:16];
		sum   = $signed({{2{s_old[23]}}, s_old}) + $signed({delta[24], delta});
		s_new = sum[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				st_q[i] <= '0;
		end else if (wr_en) begin
			st_q[wr_idx] <= s_new;
		end
	end

	assign rd_data = st_q[rd_idx];

endmodule

FILE: rtl/core/cascaded_onepole_bandpass.sv
// top level: sequencer of the two-channel cascaded one-pole band filter
//
//   port group  dir  handshake            contents
//   in_*        in   in_valid/in_ready    button, two samples, two control voltages
//   out_*       out  out_valid/out_ready  two band outputs, coefficients, flags
//   cfg_*       in   cfg_valid/cfg_ready  register index and data
//
// one word runs from accept to result through the single multiplier, with n the
// clamped pole count: one multiply for the divide-by-ten of each control voltage,
// a quotient step, a coefficient step, one multiply per stage and channel with the
// two channels interleaved, then write-back and load
// stage state clears at reset; in_ready is high only in idle
// a finished result waits in the output register while the next word is taken
`include "cascaded_onepole_bandpass_assert.svh"

module cascaded_onepole_bandpass #(
	parameter int MAX_STAGES = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        link_button,
	input  logic        in1_present,
	input  logic signed [23:0] in1_sample,
	input  logic        in2_present,
	input  logic signed [23:0] in2_sample,
	input  logic        f_cv_present,
	input  logic signed [23:0] f_cv,
	input  logic        r_cv_present,
	input  logic signed [23:0] r_cv,

	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [23:0] out1,
	output logic signed [23:0] out2,
	output logic        link_lit,
	output logic [16:0] f_coef,
	output logic [16:0] r_coef,
	output logic        f_from_cv,
	output logic        r_from_cv
);

	localparam int DEPTH = 2 * MAX_STAGES;
	localparam int IW    = $clog2(DEPTH);
	localparam int KW    = $clog2(DEPTH + 1);
	localparam int NW    = $clog2(MAX_STAGES + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIVR  = 3'd1;
	localparam logic [2:0] ST_DIVF  = 3'd2;
	localparam logic [2:0] ST_QF    = 3'd3;
	localparam logic [2:0] ST_COEF  = 3'd4;
	localparam logic [2:0] ST_RUN   = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]      state_q;
	logic [NW-1:0]   n_q;
	logic [NW-1:0]   n_eff;
	logic [KW-1:0]   k_q;
	logic            ph_q;

	logic [3:0]      pole_count_q;
	cvbp_pkg::coef_t pot_f_q;
	cvbp_pkg::coef_t pot_r_q;

	logic            link_on_q;
	cvbp_pkg::offs_t link_off_q;
	logic            prev_btn_q;
	cvbp_pkg::coef_t last_f_q;
	cvbp_pkg::coef_t last_r_q;

	logic            p1_q;
	logic            p2_q;
	logic            fp_q;
	logic            rp_q;
	cvbp_pkg::volt_t fv_q;
	cvbp_pkg::volt_t rv_q;
	cvbp_pkg::volt_t x1_q;
	cvbp_pkg::volt_t x2_q;
	cvbp_pkg::volt_t a1_q;
	cvbp_pkg::volt_t a2_q;

	cvbp_pkg::quot_t qr_q;
	cvbp_pkg::quot_t qf_q;
	cvbp_pkg::coef_t fc_q;
	cvbp_pkg::coef_t rc_q;
	logic            ffrom_q;
	logic            rfrom_q;

	logic            wb_vld_s1;
	logic            wb_ch_s1;
	logic [IW-1:0]   wb_idx_s1;
	logic            wb_lowend_s1;
	cvbp_pkg::volt_t s_old_s1;

	logic            out_valid_q;
	cvbp_pkg::volt_t out1_q;
	cvbp_pkg::volt_t out2_q;
	logic            lit_q;
	cvbp_pkg::coef_t fco_q;
	cvbp_pkg::coef_t rco_q;
	logic            ffo_q;
	logic            rfo_q;

	cvbp_pkg::coef_t fc_w;
	cvbp_pkg::coef_t rc_w;
	logic            ffrom_w;
	logic            rfrom_w;

	cvbp_pkg::opnd_t mul_a;
	cvbp_pkg::opnd_t mul_b;
	cvbp_pkg::prod_t prod;
	cvbp_pkg::quot_t quot;

	cvbp_pkg::opnd_t rv_ext;
	cvbp_pkg::opnd_t fv_ext;
	cvbp_pkg::opnd_t rmag;
	cvbp_pkg::opnd_t fmag;

	logic            is_low;
	logic            low_end;
	logic            last_issue;
	logic [IW-1:0]   rd_idx;
	cvbp_pkg::volt_t s1_rd;
	cvbp_pkg::volt_t s2_rd;
	cvbp_pkg::volt_t s_cur;
	cvbp_pkg::volt_t x_cur;
	cvbp_pkg::coef_t c_cur;
	cvbp_pkg::volt_t s1_new;
	cvbp_pkg::volt_t s2_new;
	logic            wr1;
	logic            wr2;
	logic            in_acc;
	logic            out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		if (pole_count_q == '0)
			n_eff = NW'(1);
		else if (int'(pole_count_q) > MAX_STAGES)
			n_eff = NW'(MAX_STAGES);
		else
			n_eff = NW'(pole_count_q);
	end

	// stage position in the chain: low stages first, then high stages
	always_comb begin
		is_low     = (k_q < KW'(n_q));
		low_end    = (k_q == (KW'(n_q) - KW'(1)));
		last_issue = ph_q && (k_q == (KW'({n_q, 1'b0}) - KW'(1)));
		if (is_low)
			rd_idx = IW'(k_q);
		else
			rd_idx = IW'(KW'(MAX_STAGES) + k_q - KW'(n_q));
		s_cur = ph_q ? s2_rd : s1_rd;
		x_cur = ph_q ? x2_q : x1_q;
		c_cur = is_low ? fc_q : rc_q;
	end

	always_comb begin
		rv_ext = {rv_q[23], rv_q};
		fv_ext = {fv_q[23], fv_q};
		rmag   = (rv_q[23] ? -rv_ext : rv_ext) + 25'sd5;
		fmag   = (fv_q[23] ? -fv_ext : fv_ext) + 25'sd5;
		case (state_q)
			ST_DIVR: begin
				mul_a = rmag;
				mul_b = cvbp_pkg::RECIP10;
			end
			ST_DIVF: begin
				mul_a = fmag;
				mul_b = cvbp_pkg::RECIP10;
			end
			default: begin
				mul_a = $signed({x_cur[23], x_cur}) - $signed({s_cur[23], s_cur});
				mul_b = $signed({8'b0, c_cur});
			end
		endcase
	end

	assign quot = prod[cvbp_pkg::RECIP_SHIFT+19:cvbp_pkg::RECIP_SHIFT];

	cvbp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	cvbp_coef u_coef (
		.link_on     (link_on_q),
		.link_offset (link_off_q),
		.rp          (rp_q),
		.fp          (fp_q),
		.rv          (rv_q),
		.fv          (fv_q),
		.qr          (qr_q),
		.qf          (qf_q),
		.pot_f       (pot_f_q),
		.pot_r       (pot_r_q),
		.fc          (fc_w),
		.rc          (rc_w),
		.ffrom       (ffrom_w),
		.rfrom       (rfrom_w)
	);

	assign wr1 = wb_vld_s1 && !wb_ch_s1 && p1_q;
	assign wr2 = wb_vld_s1 && wb_ch_s1 && p2_q;

	cvbp_bank #(.MAX_STAGES(MAX_STAGES)) u_bank1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.rd_data (s1_rd),
		.wr_en   (wr1),
		.wr_idx  (wb_idx_s1),
		.s_old   (s_old_s1),
		.prod    (prod),
		.s_new   (s1_new)
	);

	cvbp_bank #(.MAX_STAGES(MAX_STAGES)) u_bank2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.rd_data (s2_rd),
		.wr_en   (wr2),
		.wr_idx  (wb_idx_s1),
		.s_old   (s_old_s1),
		.prod    (prod),
		.s_new   (s2_new)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_count_q <= 4'd4;
			pot_f_q      <= cvbp_pkg::COEF_ONE;
			pot_r_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cvbp_pkg::CFG_POLE_COUNT: pole_count_q <= cfg_data[3:0];
				cvbp_pkg::CFG_POT_F:      pot_f_q      <= cfg_data;
				cvbp_pkg::CFG_POT_R:      pot_r_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= NW'(1);
			k_q         <= '0;
			ph_q        <= 1'b0;
			link_on_q   <= 1'b0;
			link_off_q  <= '0;
			prev_btn_q  <= 1'b0;
			last_f_q    <= '0;
			last_r_q    <= '0;
			wb_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wb_vld_s1 <= (state_q == ST_RUN);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						n_q        <= n_eff;
						prev_btn_q <= link_button;
						if (link_button && !prev_btn_q) begin
							if (!link_on_q) begin
								link_on_q  <= 1'b1;
								link_off_q <= $signed({1'b0, last_f_q}) -
								              $signed({1'b0, last_r_q});
							end else begin
								link_on_q <= 1'b0;
							end
						end
						state_q <= ST_DIVR;
					end
				end
				ST_DIVR:  state_q <= ST_DIVF;
				ST_DIVF:  state_q <= ST_QF;
				ST_QF:    state_q <= ST_COEF;
				ST_COEF: begin
					last_f_q <= fc_w;
					last_r_q <= rc_w;
					k_q      <= '0;
					ph_q     <= 1'b0;
					state_q  <= ST_RUN;
				end
				ST_RUN: begin
					ph_q <= !ph_q;
					if (ph_q)
						k_q <= k_q + KW'(1);
					if (last_issue)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			p1_q <= in1_present;
			p2_q <= in2_present;
			fp_q <= f_cv_present;
			rp_q <= r_cv_present;
			fv_q <= f_cv;
			rv_q <= r_cv;
			x1_q <= in1_sample;
			x2_q <= in2_sample;
		end
		if (state_q == ST_DIVF)
			qr_q <= quot;
		if (state_q == ST_QF)
			qf_q <= quot;
		if (state_q == ST_COEF) begin
			fc_q    <= fc_w;
			rc_q    <= rc_w;
			ffrom_q <= ffrom_w;
			rfrom_q <= rfrom_w;
		end
		if (state_q == ST_RUN) begin
			wb_ch_s1     <= ph_q;
			wb_idx_s1    <= rd_idx;
			wb_lowend_s1 <= low_end;
			s_old_s1     <= s_cur;
		end
		if (wr1) begin
			x1_q <= s1_new;
			if (wb_lowend_s1)
				a1_q <= s1_new;
		end
		if (wr2) begin
			x2_q <= s2_new;
			if (wb_lowend_s1)
				a2_q <= s2_new;
		end
		if (out_load) begin
			out1_q <= p1_q ? cvbp_pkg::sat_volt($signed({a1_q[23], a1_q}) -
			                                    $signed({x1_q[23], x1_q})) : '0;
			out2_q <= p2_q ? cvbp_pkg::sat_volt($signed({a2_q[23], a2_q}) -
			                                    $signed({x2_q[23], x2_q})) : '0;
			lit_q  <= link_on_q;
			fco_q  <= fc_q;
			rco_q  <= rc_q;
			ffo_q  <= ffrom_q;
			rfo_q  <= rfrom_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out1      = out1_q;
	assign out2      = out2_q;
	assign link_lit  = lit_q;
	assign f_coef    = fco_q;
	assign r_coef    = rco_q;
	assign f_from_cv = ffo_q;
	assign r_from_cv = rfo_q;

	`CVBP_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	`CVBP_ASSERT_IMP(a_coef_range, out_valid, (f_coef <= cvbp_pkg::COEF_ONE) && (r_coef <= cvbp_pkg::COEF_ONE), "coefficient above one")
	`CVBP_ASSERT_IMP(a_wb_in_run, wb_vld_s1, (state_q == ST_RUN) || (state_q == ST_DRAIN), "stage write outside run")

endmodule

FILE: sim/cascaded_onepole_bandpass_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the two-channel cascaded one-pole band filter
module cascaded_onepole_bandpass_tb;

	localparam int     POLE_MAX    = 8;
	localparam int     HOLD_CYCLES = 400;
	localparam int     DRAIN_GUARD = 20000;
	localparam int     TAIL_CYCLES = 4 * POLE_MAX + 7 + 12;
	localparam longint VOLT_HI     = 8388607;
	localparam longint VOLT_LO     = -8388608;
	localparam cvbp_pkg::volt_t V_TOP = 24'h7FFFFF;
	localparam cvbp_pkg::volt_t V_BOT = 24'h800000;

	typedef struct {
		logic            link_button;
		logic            in1_present;
		cvbp_pkg::volt_t in1_sample;
		logic            in2_present;
		cvbp_pkg::volt_t in2_sample;
		logic            f_cv_present;
		cvbp_pkg::volt_t f_cv;
		logic            r_cv_present;
		cvbp_pkg::volt_t r_cv;
	} sample_word_t;

	typedef struct {
		cvbp_pkg::volt_t out1;
		cvbp_pkg::volt_t out2;
		logic            link_lit;
		cvbp_pkg::coef_t f_coef;
		cvbp_pkg::coef_t r_coef;
		logic            f_from_cv;
		logic            r_from_cv;
	} band_result_t;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_style_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [16:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               link_button;
	logic               in1_present;
	logic signed [23:0] in1_sample;
	logic               in2_present;
	logic signed [23:0] in2_sample;
	logic               f_cv_present;
	logic signed [23:0] f_cv;
	logic               r_cv_present;
	logic signed [23:0] r_cv;
	logic               out_valid;
	logic               out_ready;
	logic signed [23:0] out1;
	logic signed [23:0] out2;
	logic               link_lit;
	logic [16:0]        f_coef;
	logic [16:0]        r_coef;
	logic               f_from_cv;
	logic               r_from_cv;

	// filter state as the block should hold it
	longint          stage_mem [4][POLE_MAX];
	bit              link_mode;
	longint          link_ofs;
	bit              btn_prev;
	longint          prev_f;
	longint          prev_r;
	logic [3:0]      pole_setting;
	cvbp_pkg::coef_t panel_f;
	cvbp_pkg::coef_t panel_r;

	band_result_t band_queue[$];
	int           mismatches;
	int           results_seen;

	int           burst_left;
	int           tx_gap_max;
	bit           btn_level;
	rx_style_t    rx_mode;
	int           rx_tick;
	int           hold_req;
	int           hold_seen;
	int           hold_count;

	cascaded_onepole_bandpass #(.MAX_STAGES(POLE_MAX)) u_top (.*);

	always #10 clk = ~clk;

	function automatic longint clamp_l(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// divide by ten, halves away from zero
	function automatic longint tenth_rounded(input longint v);
		if (v >= 0)
			return (v + 5) / 10;
		return -((-v + 5) / 10);
	endfunction

	function automatic longint cv_to_coef(input longint v);
		return (clamp_l(v, 0, longint'(cvbp_pkg::TEN_VOLTS)) + 5) / 10;
	endfunction

	function automatic longint panel_coef(input cvbp_pkg::coef_t p);
		return (p > cvbp_pkg::COEF_ONE) ? longint'(cvbp_pkg::COEF_ONE) : longint'(p);
	endfunction

	// chain ids: 2*ch is the f chain, 2*ch+1 the r chain
	function automatic longint run_chain(input int id, input int n, input longint x,
			input longint c);
		for (int i = 0; i < n; i++) begin
			stage_mem[id][i] += ((x - stage_mem[id][i]) * c + 32768) >>> 16;
			x = stage_mem[id][i];
		end
		return x;
	endfunction

	function automatic cvbp_pkg::volt_t band_out(input int ch, input int n, input longint x,
			input longint fc, input longint rc);
		longint a;
		longint b;
		a = run_chain(2 * ch, n, x, fc);
		b = run_chain(2 * ch + 1, n, a, rc);
		return cvbp_pkg::volt_t'(clamp_l(a - b, VOLT_LO, VOLT_HI));
	endfunction

	function automatic band_result_t predict_word(input sample_word_t w);
		band_result_t r;
		int           n;
		longint       fc;
		longint       rc;
		longint       one;
		bit           ff;
		bit           rf;
		one = longint'(cvbp_pkg::COEF_ONE);
		n = int'(pole_setting);
		if (n < 1)
			n = 1;
		if (n > POLE_MAX)
			n = POLE_MAX;
		if (w.link_button && !btn_prev) begin
			if (!link_mode) begin
				link_mode = 1'b1;
				link_ofs = prev_f - prev_r;
			end else begin
				link_mode = 1'b0;
			end
		end
		btn_prev = w.link_button;
		rf = w.r_cv_present;
		rc = rf ? cv_to_coef(w.r_cv) : panel_coef(panel_r);
		if (!link_mode) begin
			ff = w.f_cv_present;
			fc = ff ? cv_to_coef(w.f_cv) : panel_coef(panel_f);
		end else if (w.r_cv_present) begin
			ff = 1'b1;
			fc = clamp_l(tenth_rounded(w.r_cv) + link_ofs, 0, one);
		end else if (w.f_cv_present) begin
			rf = 1'b1;
			rc = clamp_l(tenth_rounded(w.f_cv) - link_ofs, 0, one);
			ff = 1'b1;
			fc = clamp_l(tenth_rounded(w.f_cv), 0, one);
		end else begin
			ff = 1'b1;
			fc = clamp_l(panel_coef(panel_r) + link_ofs, 0, one);
		end
		prev_f = fc;
		prev_r = rc;
		r.out1 = '0;
		r.out2 = '0;
		if (w.in1_present)
			r.out1 = band_out(0, n, w.in1_sample, fc, rc);
		if (w.in2_present)
			r.out2 = band_out(1, n, w.in2_sample, fc, rc);
		r.link_lit = link_mode;
		r.f_coef = cvbp_pkg::coef_t'(fc);
		r.r_coef = cvbp_pkg::coef_t'(rc);
		r.f_from_cv = ff;
		r.r_from_cv = rf;
		return r;
	endfunction

	function automatic sample_word_t make_word(input bit btn, input bit p1,
			input cvbp_pkg::volt_t s1, input bit p2, input cvbp_pkg::volt_t s2,
			input bit fp, input cvbp_pkg::volt_t fv, input bit rp,
			input cvbp_pkg::volt_t rv);
		sample_word_t w;
		w.link_button = btn;
		w.in1_present = p1;
		w.in1_sample = s1;
		w.in2_present = p2;
		w.in2_sample = s2;
		w.f_cv_present = fp;
		w.f_cv = fv;
		w.r_cv_present = rp;
		w.r_cv = rv;
		return w;
	endfunction

	function automatic cvbp_pkg::volt_t rand_sample();
		int v;
		case ($urandom_range(5, 0))
			0, 1, 2: v = int'($urandom_range(1310720, 0)) - 655360;
			3: v = int'($urandom());
			4: v = ($urandom_range(1, 0) != 0) ? int'(VOLT_HI) : int'(VOLT_LO);
			default: v = int'($urandom_range(510, 0)) - 255;
		endcase
		return cvbp_pkg::volt_t'(v);
	endfunction

	function automatic cvbp_pkg::volt_t rand_cv();
		int v;
		case ($urandom_range(6, 0))
			0, 1, 2: v = int'($urandom_range(655360, 0));
			3: v = 655360 + int'($urandom_range(10, 0)) - 5;
			4: v = int'($urandom_range(10, 0)) - 5;
			5: v = -int'($urandom_range(8388608, 1));
			default: v = int'($urandom());
		endcase
		return cvbp_pkg::volt_t'(v);
	endfunction

	function automatic sample_word_t rand_word(input int toggle_odds);
		sample_word_t w;
		if ($urandom_range(toggle_odds - 1, 0) == 0)
			btn_level = !btn_level;
		w.link_button = btn_level;
		w.in1_present = $urandom_range(7, 0) != 0;
		w.in1_sample = rand_sample();
		w.in2_present = $urandom_range(3, 0) != 0;
		w.in2_sample = rand_sample();
		w.f_cv_present = $urandom_range(1, 0) != 0;
		w.f_cv = rand_cv();
		w.r_cv_present = $urandom_range(1, 0) != 0;
		w.r_cv = rand_cv();
		return w;
	endfunction

	function automatic cvbp_pkg::coef_t rand_coef(input int hi);
		return cvbp_pkg::coef_t'($urandom_range(hi, 0));
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < 100)
			$display("mismatch on result %0d: %s got %0d expected %0d",
				results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic send_word(input sample_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = (tx_gap_max > 0) ? int'($urandom_range(tx_gap_max, 0)) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = int'($urandom_range(16, 1));
		end
		@(negedge clk);
		in_valid <= 1'b1;
		link_button <= w.link_button;
		in1_present <= w.in1_present;
		in1_sample <= w.in1_sample;
		in2_present <= w.in2_present;
		in2_sample <= w.in2_sample;
		f_cv_present <= w.f_cv_present;
		f_cv <= w.f_cv;
		r_cv_present <= w.r_cv_present;
		r_cv <= w.r_cv;
		burst_left--;
		do @(posedge clk); while (in_ready !== 1'b1);
		band_queue.push_back(predict_word(w));
	endtask

	task automatic run_words(input int count, input int toggle_odds);
		repeat (count) send_word(rand_word(toggle_odds));
	endtask

	// drop valid and wait for every outstanding word to come back
	task automatic wait_drained();
		int guard;
		guard = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (band_queue.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		if (band_queue.size() != 0) begin
			report_mismatch("words never returned", 0, band_queue.size());
			band_queue.delete();
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			cvbp_pkg::CFG_POLE_COUNT: pole_setting = data[3:0];
			cvbp_pkg::CFG_POT_F:      panel_f = data;
			cvbp_pkg::CFG_POT_R:      panel_r = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [3:0] poles, input cvbp_pkg::coef_t pf,
			input cvbp_pkg::coef_t pr);
		wait_drained();
		write_reg(cvbp_pkg::CFG_POLE_COUNT, {13'd0, poles});
		write_reg(cvbp_pkg::CFG_POT_F, pf);
		write_reg(cvbp_pkg::CFG_POT_R, pr);
	endtask

	// reset register values, hand-picked corners and every link case
	task automatic test_directed_cases();
		tx_gap_max = 0;
		rx_mode = RX_ALWAYS;
		send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(0, 1, V_BOT, 1, V_TOP, 1, cvbp_pkg::TEN_VOLTS, 1,
			cvbp_pkg::TEN_VOLTS));
		// f chain jumps, r chain frozen: band output saturates both ways
		send_word(make_word(0, 1, V_TOP, 1, V_BOT, 1, cvbp_pkg::TEN_VOLTS, 1, 0));
		send_word(make_word(0, 0, V_TOP, 0, V_BOT, 1, -1, 1, V_TOP));
		send_word(make_word(0, 1, 12345, 1, -54321, 1, V_BOT, 1, 655361));
		send_word(make_word(0, 1, V_TOP, 1, V_BOT, 1, 5, 1, 4));
		send_word(make_word(0, 1, -7, 1, 7, 1, 15, 1, 655355));
		// enter link with a negative offset
		send_word(make_word(1, 1, 100000, 1, -100000, 0, 0, 0, 0));
		send_word(make_word(1, 1, 3, 1, -3, 0, 0, 1, 327680));
		send_word(make_word(1, 1, V_TOP, 0, 0, 1, -5, 0, 0));
		send_word(make_word(1, 1, 0, 1, 0, 1, V_TOP, 0, 0));
		send_word(make_word(1, 0, 0, 1, 65536, 1, V_BOT, 0, 0));
		send_word(make_word(0, 1, -65536, 1, 1, 0, 0, 1, -15));
		// leave link
		send_word(make_word(1, 1, 200000, 1, 200000, 1, 163840, 0, 0));
		send_word(make_word(0, 1, V_BOT, 1, V_TOP, 1, cvbp_pkg::TEN_VOLTS, 1, 0));
		// enter link with the largest positive offset
		send_word(make_word(1, 1, 500, 1, -500, 0, 0, 0, 0));
		send_word(make_word(1, 1, 500, 1, -500, 0, 0, 1, 327680));
		send_word(make_word(1, 1, -1, 1, 1, 1, 200000, 0, 0));
		send_word(make_word(0, 1, V_TOP, 1, V_TOP, 1, -25, 1, 25));
		send_word(make_word(1, 1, 0, 1, 0, 0, 0, 0, 0));
		send_word(make_word(0, 0, 0, 0, 0, 1, 655364, 1, 655365));
	endtask

	task automatic test_register_extremes();
		configure(0, 0, 0);
		tx_gap_max = 6;
		rx_mode = RX_RANDOM;
		run_words(25, 8);
		configure(1, 17'h1FFFF, cvbp_pkg::COEF_ONE);
		rx_mode = RX_PATTERN;
		run_words(25, 8);
		configure(8, cvbp_pkg::COEF_ONE, 17'h1FFFF);
		tx_gap_max = 0;
		rx_mode = RX_ALWAYS;
		run_words(25, 8);
		configure(15, rand_coef(131071), rand_coef(131071));
		tx_gap_max = 10;
		rx_mode = RX_SLOW;
		run_words(25, 8);
		configure(4'($urandom_range(7, 2)), rand_coef(65536), rand_coef(65536));
		rx_mode = RX_RANDOM;
		run_words(25, 8);
		configure(1, 0, 17'h1FFFF);
		tx_gap_max = 3;
		run_words(25, 8);
	endtask

	task automatic test_link_sequences();
		configure(4'($urandom_range(8, 1)), rand_coef(65536), rand_coef(65536));
		tx_gap_max = 4;
		rx_mode = RX_RANDOM;
		run_words(200, 3);
	endtask

	// output held off while words keep coming, so the input side has to stall
	task automatic test_output_stall();
		configure(8, rand_coef(65536), rand_coef(65536));
		tx_gap_max = 0;
		rx_mode = RX_ALWAYS;
		hold_req++;
		run_words(40, 4);
	endtask

	task automatic test_random_mix();
		logic [3:0]      poles;
		cvbp_pkg::coef_t pf;
		cvbp_pkg::coef_t pr;
		for (int phase = 0; phase < 7; phase++) begin
			poles = ($urandom_range(7, 0) == 0) ? 4'($urandom_range(15, 0))
				: 4'($urandom_range(8, 1));
			pf = ($urandom_range(5, 0) == 0) ? rand_coef(131071) : rand_coef(65536);
			pr = ($urandom_range(5, 0) == 0) ? rand_coef(131071) : rand_coef(65536);
			configure(poles, pf, pr);
			tx_gap_max = (phase % 3 == 0) ? 0 : int'($urandom_range(12, 1));
			rx_mode = rx_style_t'(phase % 4);
			run_words(100, 8);
		end
	endtask

	// receiver ready pattern, with a long hold when requested
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_count = HOLD_CYCLES;
		end
		if (hold_count > 0) begin
			hold_count--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS:  out_ready <= 1'b1;
				RX_RANDOM:  out_ready <= $urandom_range(1, 0) != 0;
				RX_PATTERN: out_ready <= (rx_tick % 7) > 1;
				default:    out_ready <= $urandom_range(9, 0) == 0;
			endcase
		end
		rx_tick++;
	end

	always @(posedge clk) begin : check_results
		band_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (band_queue.size() == 0) begin
				report_mismatch("word with none expected, out1", out1, 0);
			end else begin
				want = band_queue.pop_front();
				if (out1 !== want.out1)
					report_mismatch("out1", out1, want.out1);
				if (out2 !== want.out2)
					report_mismatch("out2", out2, want.out2);
				if (link_lit !== want.link_lit)
					report_mismatch("link_lit", link_lit, want.link_lit);
				if (f_coef !== want.f_coef)
					report_mismatch("f_coef", f_coef, want.f_coef);
				if (r_coef !== want.r_coef)
					report_mismatch("r_coef", r_coef, want.r_coef);
				if (f_from_cv !== want.f_from_cv)
					report_mismatch("f_from_cv", f_from_cv, want.f_from_cv);
				if (r_from_cv !== want.r_from_cv)
					report_mismatch("r_from_cv", r_from_cv, want.r_from_cv);
			end
			results_seen++;
		end
	end

	initial begin
		#8_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = cvbp_pkg::CFG_POLE_COUNT;
		cfg_data = '0;
		in_valid = 1'b0;
		link_button = 1'b0;
		in1_present = 1'b0;
		in1_sample = '0;
		in2_present = 1'b0;
		in2_sample = '0;
		f_cv_present = 1'b0;
		f_cv = '0;
		r_cv_present = 1'b0;
		r_cv = '0;
		out_ready = 1'b0;
		foreach (stage_mem[i, j])
			stage_mem[i][j] = 0;
		link_mode = 1'b0;
		link_ofs = 0;
		btn_prev = 1'b0;
		prev_f = 0;
		prev_r = 0;
		pole_setting = 4'd4;
		panel_f = cvbp_pkg::COEF_ONE;
		panel_r = '0;
		mismatches = 0;
		results_seen = 0;
		burst_left = 0;
		tx_gap_max = 0;
		btn_level = 1'b0;
		rx_mode = RX_ALWAYS;
		rx_tick = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_register_extremes();
		test_link_sequences();
		test_output_stall();
		test_random_mix();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
